// ===== rtl/hkut_pkg.sv =====
// shared types and codes for the keyed usage table
package hkut_pkg;

	localparam int unsigned ENTRIES_DEFAULT = 64;

	typedef enum logic [1:0] {
		CMD_REGISTER = 2'd0,
		CMD_FIND     = 2'd1,
		CMD_UPDATE   = 2'd2,
		CMD_REPORT   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_INSERTED = 2'd1,
		STAT_FULL     = 2'd2,
		STAT_MISSING  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ,
		ST_WRITE,
		ST_SUM,
		ST_DONE
	} state_t;

	typedef struct packed {
		cmd_t        command;
		logic [31:0] hash;
		logic [31:0] verts;
		logic [31:0] raw_size;
		logic [31:0] packed_size;
	} in_t;

	typedef struct packed {
		status_t     status;
		logic [5:0]  entry_index;
		logic [6:0]  entry_count;
		logic [31:0] usage_sum;
		logic [63:0] vertex_sum;
		logic [63:0] raw_sum;
		logic [63:0] packed_sum;
		logic [63:0] total_saved;
	} out_t;

	typedef struct packed {
		logic [31:0] usage;
		logic [63:0] vertices;
		logic [63:0] raw_bytes;
		logic [63:0] packed_bytes;
	} stat_t;

endpackage

// ===== rtl/hash_keyed_usage_table.sv =====
// keyed usage table: key memory, statistics memory and sequencer
// a find scans keys from entry 0 to the first match; a register or update hit then reads
// the statistics entry and writes it back; a miss scans every filled entry, and a register
// miss with room writes a new entry; a report sums every filled entry; the scan reads one
// entry per cycle; a result waits for a free output register before the next is accepted
// reset clears the fill count and control state; memories are not cleared
module hash_keyed_usage_table import hkut_pkg::*; #(
	parameter int unsigned ENTRIES = ENTRIES_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CW = $clog2(ENTRIES + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

	state_t state_q, state_next;

	logic [31:0] key_mem [ENTRIES];
	stat_t       stat_mem [ENTRIES];
	logic [31:0] key_rd_q;
	stat_t       stat_rd_q;

	in_t         in_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] iss_q;
	logic          chk_s1;
	logic [IW-1:0] chk_idx_s1;
	logic [IW-1:0] idx_q;
	status_t       status_q;
	logic          ins_q;
	logic [63:0]   prod_raw_q, prod_packed_q;
	logic [31:0]   acc_usage_q;
	logic [63:0]   acc_vert_q, acc_raw_q, acc_packed_q;
	logic          out_valid_q;
	out_t          out_q;

	logic          accept, match, scan_end, issue, load_out;
	logic          key_we, stat_we;
	logic [IW-1:0] stat_raddr;
	stat_t         stat_wdata;

	assign accept   = in_valid && in_ready;
	assign match    = chk_s1 && (key_rd_q == in_q.hash);
	assign scan_end = !chk_s1 && (iss_q >= count_q);

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_next = (in_data.command == CMD_REPORT) ? ST_SUM : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (match) begin
					state_next = (in_q.command == CMD_FIND) ? ST_DONE : ST_READ;
				end else if (scan_end) begin
					if (in_q.command == CMD_REGISTER && count_q < FULL_COUNT) begin
						state_next = ST_WRITE;
					end else begin
						state_next = ST_DONE;
					end
				end
			end
			ST_READ:  state_next = ST_WRITE;
			ST_WRITE: state_next = ST_DONE;
			ST_SUM: begin
				if (scan_end) begin
					state_next = ST_DONE;
				end
			end
			ST_DONE: begin
				if (load_out) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		issue      = ((state_q == ST_SCAN && !match) || state_q == ST_SUM)
			&& (iss_q < count_q);
		key_we     = (state_q == ST_WRITE) && ins_q;
		stat_we    = (state_q == ST_WRITE);
		stat_raddr = (state_q == ST_SUM) ? iss_q[IW-1:0] : idx_q;
		load_out   = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	end

	always_comb begin
		stat_wdata = stat_rd_q;
		if (ins_q) begin
			stat_wdata = '{usage: 32'd1, vertices: 64'd0, raw_bytes: 64'd0, packed_bytes: 64'd0};
		end else if (in_q.command == CMD_REGISTER) begin
			stat_wdata.usage = stat_rd_q.usage + 32'd1;
		end else begin
			stat_wdata.vertices     = stat_rd_q.vertices + {32'd0, in_q.verts};
			stat_wdata.raw_bytes    = stat_rd_q.raw_bytes + prod_raw_q;
			stat_wdata.packed_bytes = stat_rd_q.packed_bytes + prod_packed_q;
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[idx_q] <= in_q.hash;
		end
		key_rd_q <= key_mem[iss_q[IW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (stat_we) begin
			stat_mem[idx_q] <= stat_wdata;
		end
		stat_rd_q <= stat_mem[stat_raddr];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			iss_q       <= '0;
			chk_s1      <= 1'b0;
			ins_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			chk_s1  <= issue;
			if (accept) begin
				iss_q <= '0;
				ins_q <= 1'b0;
			end else if (issue) begin
				iss_q <= iss_q + CW'(1);
			end
			if (state_q == ST_SCAN && !match && scan_end) begin
				ins_q <= (in_q.command == CMD_REGISTER) && (count_q < FULL_COUNT);
			end
			if (key_we) begin
				count_q <= count_q + CW'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		chk_idx_s1 <= iss_q[IW-1:0];
		if (accept) begin
			in_q         <= in_data;
			status_q     <= STAT_OK;
			idx_q        <= '0;
			acc_usage_q  <= '0;
			acc_vert_q   <= '0;
			acc_raw_q    <= '0;
			acc_packed_q <= '0;
		end
		if (state_q == ST_SCAN) begin
			if (match) begin
				idx_q    <= chk_idx_s1;
				status_q <= STAT_OK;
			end else if (scan_end) begin
				if (in_q.command == CMD_REGISTER) begin
					if (count_q < FULL_COUNT) begin
						idx_q    <= count_q[IW-1:0];
						status_q <= STAT_INSERTED;
					end else begin
						status_q <= STAT_FULL;
					end
				end else begin
					status_q <= STAT_MISSING;
				end
			end
		end
		if (state_q == ST_READ) begin
			prod_raw_q    <= {32'd0, in_q.verts} * {32'd0, in_q.raw_size};
			prod_packed_q <= {32'd0, in_q.verts} * {32'd0, in_q.packed_size};
		end
		if (state_q == ST_SUM && chk_s1) begin
			acc_usage_q  <= acc_usage_q + stat_rd_q.usage;
			acc_vert_q   <= acc_vert_q + stat_rd_q.vertices;
			acc_raw_q    <= acc_raw_q + stat_rd_q.raw_bytes;
			acc_packed_q <= acc_packed_q + stat_rd_q.packed_bytes;
		end
		if (load_out) begin
			out_q.status      <= status_q;
			out_q.entry_index <= (status_q == STAT_OK || status_q == STAT_INSERTED) ?
				6'(idx_q) : 6'd0;
			out_q.entry_count <= 7'(count_q);
			out_q.usage_sum   <= acc_usage_q;
			out_q.vertex_sum  <= acc_vert_q;
			out_q.raw_sum     <= acc_raw_q;
			out_q.packed_sum  <= acc_packed_q;
			out_q.total_saved <= acc_raw_q - acc_packed_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("fill count beyond table size");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		stat_we && !ins_q |-> CW'(idx_q) < count_q)
		else $error("statistics write to unfilled entry");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		key_we |=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not advance fill count");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside completion");

endmodule

// ===== bench/hash_keyed_usage_table_tb.sv =====
// testbench for the keyed usage table: directed, random, backpressure and table-full traffic
`timescale 1ns / 100ps

module hash_keyed_usage_table_tb;
	import hkut_pkg::*;

	localparam int ENTRIES     = ENTRIES_DEFAULT;
	localparam int KEY_POOL    = 96;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_PAUSE = 80;
	localparam int STALL_LIMIT = 3000;

	logic clk;
	logic arst_n    = 1'b0;
	logic in_valid  = 1'b0;
	logic in_ready;
	in_t  in_data   = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	hash_keyed_usage_table #(.ENTRIES(ENTRIES)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// mirror of the table contents
	logic [31:0] stored_key      [ENTRIES];
	logic [31:0] stored_usage    [ENTRIES];
	logic [63:0] stored_vertices [ENTRIES];
	logic [63:0] stored_raw      [ENTRIES];
	logic [63:0] stored_packed   [ENTRIES];
	int          stored_count = 0;

	out_t        table_replies_due[$];
	logic [31:0] key_pool[KEY_POOL];
	int          errors         = 0;
	int          send_idle_pct  = 0;
	int          recv_stall_pct = 0;
	int          hold_reqs      = 0;
	int          hold_seen      = 0;
	int          hold_left      = 0;
	int          quiet_cycles   = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic out_t compute_table_reply(input in_t item);
		out_t        reply;
		int          slot;
		logic [63:0] vc;
		logic [63:0] usz;
		logic [63:0] csz;
		reply = '0;
		slot  = -1;
		vc    = {32'd0, item.verts};
		usz   = {32'd0, item.raw_size};
		csz   = {32'd0, item.packed_size};
		for (int i = 0; i < stored_count; i++) begin
			if (slot < 0 && stored_key[i] == item.hash) begin
				slot = i;
			end
		end
		case (item.command)
			CMD_REGISTER: begin
				if (slot >= 0) begin
					stored_usage[slot] = stored_usage[slot] + 32'd1;
					reply.entry_index = slot[5:0];
				end else if (stored_count >= ENTRIES) begin
					reply.status = STAT_FULL;
				end else begin
					stored_key[stored_count]      = item.hash;
					stored_usage[stored_count]    = 32'd1;
					stored_vertices[stored_count] = '0;
					stored_raw[stored_count]      = '0;
					stored_packed[stored_count]   = '0;
					reply.status      = STAT_INSERTED;
					reply.entry_index = stored_count[5:0];
					stored_count++;
				end
			end
			CMD_FIND: begin
				if (slot >= 0) begin
					reply.entry_index = slot[5:0];
				end else begin
					reply.status = STAT_MISSING;
				end
			end
			CMD_UPDATE: begin
				if (slot >= 0) begin
					stored_vertices[slot] = stored_vertices[slot] + vc;
					stored_raw[slot]      = stored_raw[slot] + vc * usz;
					stored_packed[slot]   = stored_packed[slot] + vc * csz;
					reply.entry_index     = slot[5:0];
				end else begin
					reply.status = STAT_MISSING;
				end
			end
			default: begin
				for (int i = 0; i < stored_count; i++) begin
					reply.usage_sum   = reply.usage_sum + stored_usage[i];
					reply.vertex_sum  = reply.vertex_sum + stored_vertices[i];
					reply.raw_sum     = reply.raw_sum + stored_raw[i];
					reply.packed_sum  = reply.packed_sum + stored_packed[i];
					reply.total_saved = reply.total_saved
						+ (stored_raw[i] - stored_packed[i]);
				end
			end
		endcase
		reply.entry_count = stored_count[6:0];
		return reply;
	endfunction

	function automatic in_t make_item(input cmd_t c, input logic [31:0] h,
		input logic [31:0] v, input logic [31:0] u, input logic [31:0] p);
		in_t item;
		item.command     = c;
		item.hash        = h;
		item.verts       = v;
		item.raw_size    = u;
		item.packed_size = p;
		return item;
	endfunction

	function automatic logic [31:0] pick_key();
		int roll;
		roll = $urandom_range(99);
		if (roll < 55 && stored_count > 0) begin
			return stored_key[$urandom_range(stored_count - 1)];
		end
		if (roll < 90) begin
			return key_pool[$urandom_range(KEY_POOL - 1)];
		end
		return $urandom;
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(15);
			2: begin
				case ($urandom_range(2))
					0: return 32'h0000_0000;
					1: return 32'hFFFF_FFFF;
					default: return 32'h8000_0000;
				endcase
			end
			default: return $urandom_range(16'hFFFF);
		endcase
	endfunction

	function automatic cmd_t pick_command();
		int roll;
		roll = $urandom_range(99);
		if (roll < 35) begin
			return CMD_REGISTER;
		end
		if (roll < 55) begin
			return CMD_FIND;
		end
		if (roll < 90) begin
			return CMD_UPDATE;
		end
		return CMD_REPORT;
	endfunction

	task automatic send_item(input in_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!in_ready);
		table_replies_due.push_back(compute_table_reply(item));
	endtask

	task automatic drain_replies();
		in_valid <= 1'b0;
		while (table_replies_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_PAUSE) @(posedge clk);
	endtask

	task automatic test_directed();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_item(make_item(CMD_REPORT, 32'h0, 32'h0, 32'h0, 32'h0));
		send_item(make_item(CMD_FIND, 32'h0, 32'h0, 32'h0, 32'h0));
		send_item(make_item(CMD_UPDATE, 32'h0, 32'hFFFF_FFFF, 32'h1, 32'h1));
		send_item(make_item(CMD_REGISTER, 32'h0, 32'h0, 32'h0, 32'h0));
		send_item(make_item(CMD_REGISTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF));
		send_item(make_item(CMD_REGISTER, 32'h0, 32'h0, 32'h0, 32'h0));
		send_item(make_item(CMD_FIND, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0));
		send_item(make_item(CMD_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0));
		send_item(make_item(CMD_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF));
		send_item(make_item(CMD_UPDATE, 32'h0, 32'h1, 32'h0, 32'hFFFF_FFFF));
		send_item(make_item(CMD_UPDATE, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_item(make_item(CMD_REPORT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF));
		send_item(make_item(CMD_REGISTER, 32'h8000_0000, 32'h0, 32'h0, 32'h0));
		send_item(make_item(CMD_REGISTER, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0));
		send_item(make_item(CMD_FIND, 32'h1234_5678, 32'h0, 32'h0, 32'h0));
		send_item(make_item(CMD_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h2, 32'h1));
		send_item(make_item(CMD_UPDATE, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
			32'h5555_5555));
		send_item(make_item(CMD_FIND, 32'h8000_0000, 32'h0, 32'h0, 32'h0));
		send_item(make_item(CMD_REPORT, 32'h0, 32'h0, 32'h0, 32'h0));
	endtask

	task automatic test_random_traffic(input int count, input int send_pct,
		input int recv_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		repeat (count) begin
			send_item(make_item(pick_command(), pick_key(), pick_word(), pick_word(),
				pick_word()));
		end
	endtask

	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_reqs++;
		repeat (10) begin
			send_item(make_item(pick_command(), pick_key(), pick_word(), pick_word(),
				pick_word()));
		end
		drain_replies();
	endtask

	task automatic test_table_full();
		logic [31:0] fresh;
		send_idle_pct  = 10;
		recv_stall_pct = 10;
		while (stored_count < ENTRIES) begin
			send_item(make_item(CMD_REGISTER, $urandom, 32'h0, 32'h0, 32'h0));
		end
		fresh = $urandom;
		send_item(make_item(CMD_REGISTER, fresh, 32'h0, 32'h0, 32'h0));
		send_item(make_item(CMD_REGISTER, fresh, 32'h0, 32'h0, 32'h0));
		send_item(make_item(CMD_FIND, fresh, 32'h0, 32'h0, 32'h0));
		send_item(make_item(CMD_UPDATE, fresh, 32'h1, 32'h1, 32'h1));
		send_item(make_item(CMD_REGISTER, stored_key[ENTRIES - 1], 32'h0, 32'h0, 32'h0));
		send_item(make_item(CMD_UPDATE, stored_key[ENTRIES - 1], 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'h0));
		send_item(make_item(CMD_REPORT, 32'h0, 32'h0, 32'h0, 32'h0));
	endtask

	always @(posedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen <= hold_reqs;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic note_mismatch(input string field, input logic [63:0] want,
		input logic [63:0] got);
		$display("%0t mismatch in %s: expected %h actual %h", $time, field, want, got);
		errors++;
	endtask

	always @(posedge clk) begin : check_replies
		out_t want;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
				$display("%0t watchdog: no transaction for %0d cycles", $time, STALL_LIMIT);
				$display("tb: failure");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (out_valid && out_ready) begin
				if (table_replies_due.size() == 0) begin
					$display("%0t unexpected result: expected none actual %h", $time,
						out_data);
					errors++;
				end else begin
					want = table_replies_due.pop_front();
					if (out_data.status !== want.status)
						note_mismatch("status", 64'(want.status), 64'(out_data.status));
					if (out_data.entry_index !== want.entry_index)
						note_mismatch("entry_index", 64'(want.entry_index),
							64'(out_data.entry_index));
					if (out_data.entry_count !== want.entry_count)
						note_mismatch("entry_count", 64'(want.entry_count),
							64'(out_data.entry_count));
					if (out_data.usage_sum !== want.usage_sum)
						note_mismatch("usage_sum", 64'(want.usage_sum),
							64'(out_data.usage_sum));
					if (out_data.vertex_sum !== want.vertex_sum)
						note_mismatch("vertex_sum", want.vertex_sum, out_data.vertex_sum);
					if (out_data.raw_sum !== want.raw_sum)
						note_mismatch("raw_sum", want.raw_sum, out_data.raw_sum);
					if (out_data.packed_sum !== want.packed_sum)
						note_mismatch("packed_sum", want.packed_sum, out_data.packed_sum);
					if (out_data.total_saved !== want.total_saved)
						note_mismatch("total_saved", want.total_saved, out_data.total_saved);
				end
			end
		end
	end

	initial begin
		foreach (key_pool[i]) begin
			key_pool[i] = $urandom;
		end
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'hFFFF_FFFF;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_traffic(200, 0, 0);
		test_random_traffic(200, 61, 0);
		test_backpressure();
		test_table_full();
		test_random_traffic(200, 0, 61);
		test_random_traffic(250, 28, 28);
		drain_replies();

		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
